### rtl/core/assert_macros.svh
// Assertion macros shared by the binomial core RTL.
// Each macro expects clk and rst_n to be visible at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked outside reset.
`define BCM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication, checked outside reset.
`define BCM_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

### rtl/core/bcm_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bcm_pkg: shared types and constants for the binomial core
// Field widths, serial datapath sizes and the unit handshake structs.
// ---------------------------------------------------------------------------
package bcm_pkg;

  // field widths
  localparam int N_W    = 6;
  localparam int COEF_W = 63;

  // largest n that gets a real coefficient
  localparam int MAX_N  = 63;

  // compare width for n against MAX_N
  localparam int NX_W   = 8;

  // exact product acc * m fits here
  localparam int PROD_W = COEF_W + N_W;

  // bit counter for one serial pass
  localparam int CNT_W  = $clog2(PROD_W + 1);

  // saturation value for out-of-range n
  localparam logic [COEF_W-1:0] COEF_ALL_ONES = {COEF_W{1'b1}};

  // control word into a serial unit
  typedef struct packed {
    logic go;
  } unit_ctl_t;

  // status word out of a serial unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

endpackage

### rtl/core/binomial_multiplicative_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// binomial_multiplicative_core: binomial coefficient C(n,r)
// Takes n and r, returns C(n,r) by the multiplicative formula on serial units.
// ---------------------------------------------------------------------------
// One word in, one word out. The core takes r' = min(r, n-r) and runs r'
// steps; each step multiplies the running value by (n-i) in a bit-serial
// multiplier and then divides exactly by (i+1) in a bit-serial divider.
// r above n gives 0; r' of zero gives 1; n above MAX_N saturates to all
// ones. One item is worked at a time; the next word is taken while a finished
// result still waits in the output register.
`include "assert_macros.svh"

module binomial_multiplicative_core
  import bcm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [N_W-1:0]    in_n,
  input  logic [N_W-1:0]    in_r,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [COEF_W-1:0] out_coefficient
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_FIN
  } state_t;

  state_t            state_r;
  logic [COEF_W-1:0] acc_r;
  logic [N_W-1:0]    n_r;
  logic [N_W-1:0]    k_r;
  logic [N_W-1:0]    i_r;
  logic              mul_go_r;
  logic              div_go_r;
  logic              out_valid_r;
  logic [COEF_W-1:0] out_coef_r;

  unit_ctl_t         mul_ctl, div_ctl;
  unit_sts_t         mul_sts, div_sts;
  logic [PROD_W-1:0] mul_prod;
  logic [PROD_W-1:0] div_quot;

  logic              in_fire;
  logic              n_over;
  logic              r_over;
  logic [N_W-1:0]    n_minus_r;
  logic [N_W-1:0]    k_in;
  logic [N_W-1:0]    i_inc;

  // input decode
  always_comb begin
    in_fire   = in_valid && !in_stall;
    n_over    = (NX_W'(in_n) > NX_W'(MAX_N));
    r_over    = (in_r > in_n);
    n_minus_r = in_n - in_r;
    k_in      = (in_r > n_minus_r) ? n_minus_r : in_r;
    i_inc     = i_r + N_W'(1);
  end

  // serial units
  assign mul_ctl.go = mul_go_r;
  assign div_ctl.go = div_go_r;

  bcm_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mul_ctl),
    .acc   (acc_r),
    .mult  (n_r - i_r),
    .sts   (mul_sts),
    .prod  (mul_prod)
  );

  bcm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (div_ctl),
    .dividend (mul_prod),
    .divisor  (i_inc),
    .sts      (div_sts),
    .quot     (div_quot)
  );

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mul_go_r    <= 1'b0;
      div_go_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      mul_go_r <= 1'b0;
      div_go_r <= 1'b0;
      // word taken; in S_FIN the register is refilled instead
      if (out_valid_r && !out_stall && state_r != S_FIN) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            n_r <= in_n;
            k_r <= k_in;
            i_r <= '0;
            priority if (n_over) begin
              acc_r   <= COEF_ALL_ONES;
              state_r <= S_FIN;
            end else if (r_over) begin
              acc_r   <= '0;
              state_r <= S_FIN;
            end else if (k_in == '0) begin
              acc_r   <= COEF_W'(1);
              state_r <= S_FIN;
            end else begin
              acc_r    <= COEF_W'(1);
              mul_go_r <= 1'b1;
              state_r  <= S_MUL;
            end
          end
        end
        S_MUL: begin
          if (mul_sts.done) begin
            div_go_r <= 1'b1;
            state_r  <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_sts.done) begin
            acc_r <= div_quot[COEF_W-1:0];
            i_r   <= i_inc;
            if (i_inc == k_r) begin
              state_r <= S_FIN;
            end else begin
              mul_go_r <= 1'b1;
              state_r  <= S_MUL;
            end
          end
        end
        S_FIN: begin
          if (!out_valid_r || !out_stall) begin
            out_coef_r  <= acc_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_coefficient = out_coef_r;

  // checks
  `BCM_ASSERT(a_units_exclusive, !(mul_sts.busy && div_sts.busy), "mul and div both busy")
  `BCM_ASSERT_IMPL(a_mul_done_state, mul_sts.done, state_r == S_MUL, "mul done outside S_MUL")
  `BCM_ASSERT_IMPL(a_div_done_state, div_sts.done, state_r == S_DIV, "div done outside S_DIV")
  `BCM_ASSERT_IMPL(a_step_range, (state_r == S_MUL || state_r == S_DIV), i_r < k_r,
                   "step index past end")

endmodule

### rtl/core/bcm_mul.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bcm_mul: bit-serial multiplier
// Multiplies the running coefficient by a 6-bit factor, one bit per cycle,
// LSB first, with a narrow carry register.
// ---------------------------------------------------------------------------
module bcm_mul
  import bcm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  unit_ctl_t         ctl,
  input  logic [COEF_W-1:0] acc,
  input  logic [N_W-1:0]    mult,
  output unit_sts_t         sts,
  output logic [PROD_W-1:0] prod
);

  logic [COEF_W-1:0] a_r,     a_nxt;
  logic [PROD_W-1:0] p_r,     p_nxt;
  logic [N_W-1:0]    carry_r, carry_nxt;
  logic [N_W-1:0]    m_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [N_W:0]      sum;

  // one product bit per cycle; carry stays below the factor
  always_comb begin
    sum       = {1'b0, carry_r} + ({(N_W + 1){a_r[0]}} & {1'b0, m_r});
    carry_nxt = sum[N_W:1];
    a_nxt     = {1'b0, a_r[COEF_W-1:1]};
    p_nxt     = {sum[0], p_r[PROD_W-1:1]};
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.go) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(PROD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (ctl.go) begin
      a_r     <= acc;
      m_r     <= mult;
      carry_r <= '0;
      p_r     <= '0;
    end else if (busy_r) begin
      a_r     <= a_nxt;
      carry_r <= carry_nxt;
      p_r     <= p_nxt;
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign prod     = p_r;

endmodule

### rtl/core/bcm_div.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bcm_div: bit-serial restoring divider
// Divides the product by a small divisor, MSB first, one quotient bit per
// cycle; the quotient builds up in place of the dividend.
// ---------------------------------------------------------------------------
module bcm_div
  import bcm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  unit_ctl_t         ctl,
  input  logic [PROD_W-1:0] dividend,
  input  logic [N_W-1:0]    divisor,
  output unit_sts_t         sts,
  output logic [PROD_W-1:0] quot
);

  logic [PROD_W-1:0] q_r,   q_nxt;
  logic [N_W-1:0]    rem_r, rem_nxt;
  logic [N_W-1:0]    d_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [N_W:0]      trial;
  logic [N_W:0]      diff;
  logic              qbit;

  // shift in next dividend bit, subtract when it fits
  always_comb begin
    trial   = {rem_r, q_r[PROD_W-1]};
    diff    = trial - {1'b0, d_r};
    qbit    = (trial >= {1'b0, d_r});
    rem_nxt = qbit ? diff[N_W-1:0] : trial[N_W-1:0];
    q_nxt   = {q_r[PROD_W-2:0], qbit};
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.go) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(PROD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (ctl.go) begin
      q_r   <= dividend;
      d_r   <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quot     = q_r;

endmodule
